// ===== hdl/assd_pkg.sv =====
// shared types, constants and the ascii glyph table for the scan driver
package assd_pkg;

    // default digit count and fixed field widths
    localparam int DIGIT_COUNT_DEF = 6;
    localparam int CHAR_COUNT      = 6;
    localparam int CHAR_W          = 8;
    localparam int GLYPH_W         = 7;

    // action codes of an input word
    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // glyph table layout
    localparam int TABLE_EQUALS     = 26;
    localparam int TABLE_DASH       = 27;
    localparam int TABLE_DIGIT_BASE = 28;
    localparam int TABLE_IDX_W      = 6;

    typedef logic [CHAR_W-1:0]      t_char;
    typedef logic [GLYPH_W-1:0]     t_glyph;
    typedef logic [TABLE_IDX_W-1:0] t_table_idx;

    localparam t_glyph BLANK_GLYPH = 7'h00;

    // digit selected by a tick, as handed from the store to the output register
    typedef struct packed {
        logic [CHAR_COUNT-1:0] enable;
        t_glyph                segments;
        logic                  point;
    } t_digit_view;

    // 38-entry glyph table: letters, equals, dash, digits
    function automatic t_glyph glyph_rom(input t_table_idx idx);
        t_glyph g;
        case (idx)
            6'd0:    g = 7'h77;
            6'd1:    g = 7'h7C;
            6'd2:    g = 7'h39;
            6'd3:    g = 7'h5E;
            6'd4:    g = 7'h79;
            6'd5:    g = 7'h71;
            6'd6:    g = 7'h3D;
            6'd7:    g = 7'h76;
            6'd8:    g = 7'h30;
            6'd9:    g = 7'h0E;
            6'd10:   g = 7'h00;
            6'd11:   g = 7'h38;
            6'd12:   g = 7'h00;
            6'd13:   g = 7'h54;
            6'd14:   g = 7'h3F;
            6'd15:   g = 7'h73;
            6'd16:   g = 7'h67;
            6'd17:   g = 7'h50;
            6'd18:   g = 7'h6D;
            6'd19:   g = 7'h78;
            6'd20:   g = 7'h1C;
            6'd21:   g = 7'h00;
            6'd22:   g = 7'h00;
            6'd23:   g = 7'h00;
            6'd24:   g = 7'h6E;
            6'd25:   g = 7'h5B;
            6'd26:   g = 7'h48;
            6'd27:   g = 7'h40;
            6'd28:   g = 7'h3F;
            6'd29:   g = 7'h06;
            6'd30:   g = 7'h5B;
            6'd31:   g = 7'h4F;
            6'd32:   g = 7'h66;
            6'd33:   g = 7'h6D;
            6'd34:   g = 7'h7D;
            6'd35:   g = 7'h07;
            6'd36:   g = 7'h7F;
            6'd37:   g = 7'h6F;
            default: g = BLANK_GLYPH;
        endcase
        return g;
    endfunction

    // ascii code to glyph, anything outside the table is blank
    function automatic t_glyph glyph_of(input t_char c);
        t_glyph g;
        g = BLANK_GLYPH;
        if (c inside {[8'h41:8'h5A]}) begin
            g = glyph_rom(TABLE_IDX_W'(c - 8'h41));
        end else if (c inside {[8'h61:8'h7A]}) begin
            g = glyph_rom(TABLE_IDX_W'(c - 8'h61));
        end else if (c inside {[8'h30:8'h39]}) begin
            g = glyph_rom(TABLE_IDX_W'(TABLE_DIGIT_BASE) + TABLE_IDX_W'(c - 8'h30));
        end else if (c == 8'h2D) begin
            g = glyph_rom(TABLE_IDX_W'(TABLE_DASH));
        end else if (c == 8'h3D) begin
            g = glyph_rom(TABLE_IDX_W'(TABLE_EQUALS));
        end
        return g;
    endfunction

endpackage

// ===== hdl/assd_in_if.sv =====
// input channel: load or tick word with six characters and a point mask
interface assd_in_if
    import assd_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  action;
    t_char char_0;
    t_char char_1;
    t_char char_2;
    t_char char_3;
    t_char char_4;
    t_char char_5;
    logic [CHAR_COUNT-1:0] point_mask;

    modport source (
        output valid, action, char_0, char_1, char_2, char_3, char_4, char_5, point_mask,
        input  ready
    );
    modport sink (
        input  valid, action, char_0, char_1, char_2, char_3, char_4, char_5, point_mask,
        output ready
    );
endinterface

// ===== hdl/assd_out_if.sv =====
// output channel: selected digit, its segments and its point
interface assd_out_if
    import assd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CHAR_COUNT-1:0] digit_enable;
    t_glyph                segment_bits;
    logic                  point_on;

    modport source (
        output valid, digit_enable, segment_bits, point_on,
        input  ready
    );
    modport sink (
        input  valid, digit_enable, segment_bits, point_on,
        output ready
    );
endinterface

// ===== hdl/assd_glyph_map.sv =====
// maps the six characters of a load word to glyphs in digit order
module assd_glyph_map
    import assd_pkg::*;
(
    input  t_char  [CHAR_COUNT-1:0] i_chars,
    output t_glyph [CHAR_COUNT-1:0] o_glyphs
);

    // string position i lands on digit (last - i)
    always_comb begin
        for (int d = 0; d < CHAR_COUNT; d++) begin
            o_glyphs[d] = glyph_of(i_chars[CHAR_COUNT-1-d]);
        end
    end

endmodule

// ===== hdl/assd_digit_store.sv =====
// glyph and point registers per digit, scan index and digit readout
module assd_digit_store
    import assd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  t_glyph      [CHAR_COUNT-1:0]     i_glyphs,
    input  logic        [CHAR_COUNT-1:0]     i_points,
    input  logic                             i_tick,
    output t_digit_view                      o_view
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    t_glyph           r_glyph [DIGIT_COUNT];
    logic             r_point [DIGIT_COUNT];
    logic [IDX_W-1:0] r_scan_idx;
    logic [IDX_W-1:0] n_scan_idx;

    // per-digit storage, digits past the load width stay blank
    for (genvar d = 0; d < DIGIT_COUNT; d++) begin : g_digit
        if (d < CHAR_COUNT) begin : g_loaded
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_glyph[d] <= BLANK_GLYPH;
                    r_point[d] <= 1'b0;
                end else if (i_load) begin
                    r_glyph[d] <= i_glyphs[d];
                    r_point[d] <= i_points[d];
                end
            end
        end else begin : g_blank
            always_ff @(posedge i_clk) begin
                r_glyph[d] <= BLANK_GLYPH;
                r_point[d] <= 1'b0;
            end
        end
    end

    // scan index advances and wraps on a tick
    always_comb begin
        if (r_scan_idx >= LAST_IDX) begin
            n_scan_idx = '0;
        end else begin
            n_scan_idx = r_scan_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
        end else if (i_tick) begin
            r_scan_idx <= n_scan_idx;
        end
    end

    // readout of the digit the next tick selects
    always_comb begin
        for (int k = 0; k < CHAR_COUNT; k++) begin
            o_view.enable[k] = (int'(n_scan_idx) == k);
        end
        o_view.segments = r_glyph[n_scan_idx];
        o_view.point    = r_point[n_scan_idx];
    end

    // scan index never leaves the digit range
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_scan_idx) < DIGIT_COUNT)
        else $error("scan index out of range");

    // index only moves on a tick
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_scan_idx))
        else $error("scan index moved without a tick");

endmodule

// ===== hdl/ascii_seven_segment_scan_driver.sv =====
// top level of the ascii seven-segment scan driver
//
// One input channel (i_in) and one output channel (o_out), both valid/ready.
// A load word (action = 0) maps six ascii characters to glyphs and stores
// them, char_0 on the leftmost digit, together with the decimal-point mask;
// it produces no output word. A tick word (action = 1) advances the scan
// index, wrapping after the last digit, and produces one output word with
// the one-hot digit select, the segments a..g and the point of that digit.
// Latency: the output word is valid the cycle after the tick is accepted.
// Throughput: one input word per cycle while no output word is stalled; the
// glyph lookup sits between the input port and the digit registers, the digit
// readout between the digit registers and the output register.
// Reset: all digits blank, all points off, scan index at digit 0, so the
// first tick shows digit 1. No output word is pending after reset.
// Stall: while an output word waits on a low o_out.ready, i_in.ready is low;
// a word is taken again in the cycle the pending result is taken.
module ascii_seven_segment_scan_driver
    import assd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    assd_in_if.sink     i_in,
    assd_out_if.source  o_out
);

    logic        in_accept;
    logic        load_accept;
    logic        tick_accept;
    t_char       [CHAR_COUNT-1:0] chars;
    t_glyph      [CHAR_COUNT-1:0] glyphs;
    t_digit_view view;
    logic        r_out_valid;
    t_digit_view r_view;

    // input handshake
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign load_accept = in_accept && (i_in.action == ACTION_LOAD);
    assign tick_accept = in_accept && (i_in.action == ACTION_TICK);

    assign chars[0] = i_in.char_0;
    assign chars[1] = i_in.char_1;
    assign chars[2] = i_in.char_2;
    assign chars[3] = i_in.char_3;
    assign chars[4] = i_in.char_4;
    assign chars[5] = i_in.char_5;

    // ascii to glyph lookup
    assd_glyph_map u_glyph_map (
        .i_chars  (chars),
        .o_glyphs (glyphs)
    );

    // digit registers and scan index
    assd_digit_store #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_digit_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_accept),
        .i_glyphs (glyphs),
        .i_points (i_in.point_mask),
        .i_tick   (tick_accept),
        .o_view   (view)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_view <= view;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.digit_enable = r_view.enable;
    assign o_out.segment_bits = r_view.segments;
    assign o_out.point_on     = r_view.point;

    // a load never leaves a word pending
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_accept |=> !r_out_valid)
        else $error("load produced an output word");

    // a tick always leaves a word pending
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> r_out_valid)
        else $error("tick produced no output word");

    // at most one digit selected
    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_view.enable))
        else $error("more than one digit selected");

endmodule

// ===== bench/ascii_seven_segment_scan_driver_test.sv =====
// self-checking bench for the ascii seven-segment scan driver against a display model
module ascii_seven_segment_scan_driver_test;
    import assd_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 1650;

    // one input word as offered on the input channel
    typedef struct packed {
        logic                        action;
        t_char [CHAR_COUNT-1:0]      chars;
        logic [CHAR_COUNT-1:0]       mask;
    } t_scan_word;

    // segment patterns: letters a..z, equals, dash, digits 0..9
    localparam t_glyph SEG_TABLE [38] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h0E,
        7'h00, 7'h38, 7'h00, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h1C, 7'h00, 7'h00, 7'h00, 7'h6E, 7'h5B,
        7'h48, 7'h40,
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic i_clk;
    logic i_rst_n;

    assd_in_if  in_ch ();
    assd_out_if out_ch ();

    ascii_seven_segment_scan_driver #(
        .DIGIT_COUNT(DIGIT_COUNT_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // display model and expected digit words
    t_glyph      shown_glyph [DIGIT_COUNT_DEF];
    logic        shown_point [DIGIT_COUNT_DEF];
    int unsigned scan_pos;
    t_digit_view pending_views [$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned words_sent;

    // pacing controls for the sender and the receiver
    bit          tx_eager;
    bit          rx_eager;
    int unsigned rx_hold;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ascii code to segments
    function automatic t_glyph segments_for(t_char c);
        if (c >= "A" && c <= "Z") return SEG_TABLE[c - "A"];
        if (c >= "a" && c <= "z") return SEG_TABLE[c - "a"];
        if (c >= "0" && c <= "9") return SEG_TABLE[TABLE_DIGIT_BASE + (c - "0")];
        if (c == "-")             return SEG_TABLE[TABLE_DASH];
        if (c == "=")             return SEG_TABLE[TABLE_EQUALS];
        return BLANK_GLYPH;
    endfunction

    // update the display model for one accepted word
    task automatic track_display(t_scan_word w);
        t_digit_view v;
        if (w.action == ACTION_LOAD) begin
            for (int i = 0; i < CHAR_COUNT; i++) begin
                shown_glyph[CHAR_COUNT-1-i] = segments_for(w.chars[i]);
                shown_point[i]              = w.mask[i];
            end
        end else begin
            scan_pos = (scan_pos >= DIGIT_COUNT_DEF - 1) ? 0 : scan_pos + 1;
            v.enable   = CHAR_COUNT'(1) << scan_pos;
            v.segments = shown_glyph[scan_pos];
            v.point    = shown_point[scan_pos];
            pending_views.push_back(v);
        end
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("mismatch %s at cycle %0d: got %0h want %0h", field, cycle_count, got, want);
        fail_count++;
    endtask

    // check each digit word taken from the output
    initial begin : check_views
        t_digit_view want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_views.size() == 0) begin
                    report_mismatch("unexpected word", out_ch.digit_enable, 0);
                end else begin
                    want = pending_views.pop_front();
                    if (out_ch.digit_enable !== want.enable)
                        report_mismatch("digit_enable", out_ch.digit_enable, want.enable);
                    if (out_ch.segment_bits !== want.segments)
                        report_mismatch("segment_bits", out_ch.segment_bits, want.segments);
                    if (out_ch.point_on !== want.point)
                        report_mismatch("point_on", out_ch.point_on, want.point);
                end
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial begin : drive_ready
        int unsigned gap_left;
        int unsigned r;
        gap_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold--;
            end else if (gap_left > 0) begin
                out_ch.ready <= 1'b0;
                gap_left--;
            end else if (rx_eager) begin
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    out_ch.ready <= 1'b1;
                end else if (r < 95) begin
                    out_ch.ready <= 1'b0;
                    gap_left = $urandom_range(0, 2);
                end else begin
                    out_ch.ready <= 1'b0;
                    gap_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // offer one word and wait until it is taken
    task automatic send_word(t_scan_word w);
        in_ch.valid      <= 1'b1;
        in_ch.action     <= w.action;
        in_ch.char_0     <= w.chars[0];
        in_ch.char_1     <= w.chars[1];
        in_ch.char_2     <= w.chars[2];
        in_ch.char_3     <= w.chars[3];
        in_ch.char_4     <= w.chars[4];
        in_ch.char_5     <= w.chars[5];
        in_ch.point_mask <= w.mask;
        do @(posedge i_clk); while (!in_ch.ready);
        track_display(w);
        words_sent++;
    endtask

    // send, then maybe leave a gap
    task automatic send_paced(t_scan_word w);
        int unsigned r;
        int unsigned gap;
        send_word(w);
        gap = 0;
        if (!tx_eager) begin
            r = $urandom_range(0, 99);
            if (r >= 95)      gap = $urandom_range(10, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // tick with junk in the ignored fields
    function automatic t_scan_word tick_word();
        t_scan_word w;
        w.action = ACTION_TICK;
        for (int i = 0; i < CHAR_COUNT; i++) w.chars[i] = t_char'($urandom);
        w.mask = CHAR_COUNT'($urandom);
        return w;
    endfunction

    function automatic t_scan_word load_word(t_char c0, t_char c1, t_char c2, t_char c3,
                                             t_char c4, t_char c5,
                                             logic [CHAR_COUNT-1:0] m);
        t_scan_word w;
        w.action   = ACTION_LOAD;
        w.chars[0] = c0;
        w.chars[1] = c1;
        w.chars[2] = c2;
        w.chars[3] = c3;
        w.chars[4] = c4;
        w.chars[5] = c5;
        w.mask     = m;
        return w;
    endfunction

    // mostly table characters, sometimes any byte
    function automatic t_char pick_char();
        case ($urandom_range(0, 9))
            0, 1:    return t_char'($urandom_range(8'h41, 8'h5A));
            2:       return t_char'($urandom_range(8'h61, 8'h7A));
            3, 4:    return t_char'($urandom_range(8'h30, 8'h39));
            5:       return "-";
            6:       return "=";
            7:       return ($urandom_range(0, 1) != 0) ? t_char'(8'h20) : t_char'(8'h00);
            default: return t_char'($urandom);
        endcase
    endfunction

    function automatic t_scan_word random_load();
        return load_word(pick_char(), pick_char(), pick_char(), pick_char(),
                         pick_char(), pick_char(), CHAR_COUNT'($urandom));
    endfunction

    // blank display after reset, scan starts at digit 1
    task automatic test_reset_state();
        repeat (DIGIT_COUNT_DEF) send_paced(tick_word());
    endtask

    // extreme codes, unknown codes, letters without glyph, both cases
    task automatic test_glyph_edges();
        send_paced(load_word(8'h00, 8'hFF, "A", "z", "9", "=", 6'h3F));
        repeat (DIGIT_COUNT_DEF) send_paced(tick_word());
        send_paced(load_word(" ", "-", "k", "0", "Z", "a", 6'h2A));
        repeat (DIGIT_COUNT_DEF) send_paced(tick_word());
    endtask

    // long output hold-off while ticks keep coming
    task automatic test_output_stall();
        tx_eager = 1'b1;
        rx_hold  = 200;
        send_paced(random_load());
        repeat (30) send_paced(tick_word());
        tx_eager = 1'b0;
    endtask

    // sender stops until every word is out, then resumes back to back
    task automatic test_drain_pause();
        send_paced(random_load());
        repeat (9) send_paced(tick_word());
        in_ch.valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        tx_eager = 1'b1;
        rx_eager = 1'b1;
        send_paced(random_load());
        repeat (12) send_paced(tick_word());
        send_paced(random_load());
        send_paced(tick_word());
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // load followed by a run of ticks, with some noise words in between
    task automatic test_random_traffic();
        int unsigned stop_at;
        stop_at = words_sent + RANDOM_ITEMS;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                tx_eager = $urandom_range(0, 1);
                rx_eager = $urandom_range(0, 1);
            end
            if ($urandom_range(0, 99) < 85) begin
                send_paced(random_load());
                repeat ($urandom_range(1, 14)) send_paced(tick_word());
            end else if ($urandom_range(0, 1) != 0) begin
                send_paced(random_load());
            end else begin
                send_paced(tick_word());
            end
        end
        tx_eager = 1'b0;
        rx_eager = 1'b0;
    endtask

    // reset, tests, drain and verdict
    initial begin
        fail_count  = 0;
        cycle_count = 0;
        words_sent  = 0;
        tx_eager    = 1'b0;
        rx_eager    = 1'b0;
        rx_hold     = 0;
        scan_pos    = 0;
        for (int i = 0; i < DIGIT_COUNT_DEF; i++) begin
            shown_glyph[i] = BLANK_GLYPH;
            shown_point[i] = 1'b0;
        end
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACTION_LOAD;
        in_ch.char_0     <= '0;
        in_ch.char_1     <= '0;
        in_ch.char_2     <= '0;
        in_ch.char_3     <= '0;
        in_ch.char_4     <= '0;
        in_ch.char_5     <= '0;
        in_ch.point_mask <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_glyph_edges();
        test_output_stall();
        test_drain_pause();
        test_random_traffic();

        in_ch.valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
